[hw/rtl/force_vector_polar_motor_drive_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the force vector polar motor drive unit
// Each macro samples on clk and is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef FORCE_VECTOR_POLAR_MOTOR_DRIVE_UNIT_DEFINES_SVH
`define FORCE_VECTOR_POLAR_MOTOR_DRIVE_UNIT_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent
`define FVP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent
`define FVP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fvp_pkg.sv]
// ---------------------------------------------------------------------------
// fvp_pkg
// Shared constants, codes and types of the force vector polar motor drive.
// ---------------------------------------------------------------------------
package fvp_pkg;

	// Default parameter values
	localparam int FORCE_BITS_DEF    = 18;
	localparam int CORDIC_STAGES_DEF = 20;

	// Fixed field widths
	localparam int SPEED_BITS = 14;
	localparam int DPU_BITS   = 16;
	localparam int DUTY_BITS  = 24;
	localparam int DEG_BITS   = 9;
	localparam int CLS_BITS   = 3;
	localparam int WR_IDX_BITS  = 1;
	localparam int WR_DATA_BITS = 24;

	// Configuration register indexes
	localparam logic [WR_IDX_BITS-1:0] REG_DUTY_PER_UNIT = 1'd0;
	localparam logic [WR_IDX_BITS-1:0] REG_PWM_PERIOD    = 1'd1;

	// Configuration reset values
	localparam logic [DPU_BITS-1:0]  DPU_RESET    = 16'd1000;
	localparam logic [DUTY_BITS-1:0] PERIOD_RESET = 24'd5000000;

	// Decoupling queue between classifier and CORDIC back end
	localparam int QUEUE_DEPTH = 4;
	localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

	// CORDIC number formats: binary angle with a full turn of 2^32
	localparam int COMP_BITS = 64;
	localparam int Z_BITS    = 34;
	localparam int FRAC_TOP  = 60;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
	localparam logic [DEG_BITS-1:0] DEG_TURN = 9'd360;

	// atan(2^-i) in binary angle units
	localparam logic [31:0] ATAN_TURN [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	// Direction class of one force vector
	typedef logic [CLS_BITS-1:0] cls_t;
	localparam cls_t CLS_POS_X = 3'd0;
	localparam cls_t CLS_NEG_X = 3'd1;
	localparam cls_t CLS_POS_Y = 3'd2;
	localparam cls_t CLS_NEG_Y = 3'd3;
	localparam cls_t CLS_Q1    = 3'd4;
	localparam cls_t CLS_Q2    = 3'd5;
	localparam cls_t CLS_Q3    = 3'd6;
	localparam cls_t CLS_Q4    = 3'd7;

	// Queue status seen by both sides
	typedef struct packed {
		logic                  empty;
		logic [LEVEL_BITS-1:0] level;
	} q_stat_t;

endpackage

[hw/rtl/fvp_front.sv]
// ---------------------------------------------------------------------------
// fvp_front
// Accepts requests, folds the force into the first quadrant, classifies its
// direction and works out bridge pins and clamped PWM duty.
// ---------------------------------------------------------------------------
module fvp_front #(
	parameter int FORCE_BITS = fvp_pkg::FORCE_BITS_DEF,
	parameter int ENTRY_W    = 2 * FORCE_BITS + fvp_pkg::CLS_BITS + 2 + fvp_pkg::DUTY_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [FORCE_BITS-1:0]        force_x,
	input  logic signed [FORCE_BITS-1:0]        force_y,
	input  logic signed [fvp_pkg::SPEED_BITS-1:0] speed_z,
	input  logic                                wr_en,
	input  logic [fvp_pkg::WR_IDX_BITS-1:0]     wr_idx,
	input  logic [fvp_pkg::WR_DATA_BITS-1:0]    wr_data,
	input  fvp_pkg::q_stat_t                    q_stat,
	output logic                                push,
	output logic [ENTRY_W-1:0]                  push_data
);

	localparam int SB = fvp_pkg::SPEED_BITS;
	localparam int DB = fvp_pkg::DUTY_BITS;
	localparam int PB = SB + fvp_pkg::DPU_BITS;
	localparam int LEVEL_BITS1 = fvp_pkg::LEVEL_BITS + 1;

	logic [fvp_pkg::DPU_BITS-1:0] dpu_q;
	logic [DB-1:0]                period_q;

	logic [FORCE_BITS-1:0] fx_u, fy_u, ax, ay;
	logic [SB-1:0]         sz_u, spd_abs;
	logic                  fx_zero, fy_zero;
	fvp_pkg::cls_t         cls;
	logic                  in_acc;

	logic                  v_s1;
	logic [FORCE_BITS-1:0] ax_s1, ay_s1;
	fvp_pkg::cls_t         cls_s1;
	logic                  dira_s1, dirb_s1;
	logic [SB-1:0]         spd_s1;

	logic [PB-1:0]         duty_prod;
	logic [DB-1:0]         duty_clamp;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpu_q    <= fvp_pkg::DPU_RESET;
			period_q <= fvp_pkg::PERIOD_RESET;
		end else if (wr_en) begin
			case (wr_idx)
				fvp_pkg::REG_DUTY_PER_UNIT: dpu_q    <= wr_data[fvp_pkg::DPU_BITS-1:0];
				fvp_pkg::REG_PWM_PERIOD:    period_q <= wr_data[DB-1:0];
				default: ;
			endcase
		end
	end

	// Stall while the queue could not take what is already in flight
	assign in_stall = (({1'b0, q_stat.level}) + (LEVEL_BITS1'(v_s1))) >=
		(LEVEL_BITS1'(fvp_pkg::QUEUE_DEPTH));
	assign in_acc = in_valid && !in_stall;

	// Fold into first quadrant
	always_comb begin
		fx_u    = force_x;
		fy_u    = force_y;
		sz_u    = speed_z;
		ax      = fx_u[FORCE_BITS-1] ? (~fx_u + 1'b1) : fx_u;
		ay      = fy_u[FORCE_BITS-1] ? (~fy_u + 1'b1) : fy_u;
		spd_abs = sz_u[SB-1] ? (~sz_u + 1'b1) : sz_u;
		fx_zero = (fx_u == '0);
		fy_zero = (fy_u == '0);
	end

	// Classify direction: axes are exact, quadrants go to the CORDIC
	always_comb begin
		if (fy_zero)
			cls = fx_u[FORCE_BITS-1] ? fvp_pkg::CLS_NEG_X : fvp_pkg::CLS_POS_X;
		else if (fx_zero)
			cls = fy_u[FORCE_BITS-1] ? fvp_pkg::CLS_NEG_Y : fvp_pkg::CLS_POS_Y;
		else if (!fx_u[FORCE_BITS-1] && !fy_u[FORCE_BITS-1])
			cls = fvp_pkg::CLS_Q1;
		else if (fx_u[FORCE_BITS-1] && !fy_u[FORCE_BITS-1])
			cls = fvp_pkg::CLS_Q2;
		else if (fx_u[FORCE_BITS-1])
			cls = fvp_pkg::CLS_Q3;
		else
			cls = fvp_pkg::CLS_Q4;
	end

	// Register the classified request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_acc;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ax_s1   <= ax;
			ay_s1   <= ay;
			cls_s1  <= cls;
			dira_s1 <= !sz_u[SB-1] && (sz_u != '0);
			dirb_s1 <= sz_u[SB-1];
			spd_s1  <= spd_abs;
		end
	end

	// Scale speed to duty and clamp to the period
	always_comb begin
		duty_prod  = PB'(spd_s1) * PB'(dpu_q);
		duty_clamp = (duty_prod > PB'(period_q)) ? period_q : duty_prod[DB-1:0];
	end

	assign push      = v_s1;
	assign push_data = {ax_s1, ay_s1, cls_s1, dira_s1, dirb_s1, duty_clamp};

endmodule

[hw/rtl/fvp_queue.sv]
// ---------------------------------------------------------------------------
// fvp_queue
// Short request queue between the classifier and the CORDIC back end.
// ---------------------------------------------------------------------------
module fvp_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output fvp_pkg::q_stat_t stat
);

	localparam int DEPTH    = fvp_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int LB       = fvp_pkg::LEVEL_BITS;

	logic [WIDTH-1:0]    entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [LB-1:0]       level_q;

	// Store pushed requests
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	assign pop_data   = entry_q[rd_ptr_q];
	assign stat.empty = (level_q == '0);
	assign stat.level = level_q;

endmodule

[hw/rtl/fvp_back.sv]
// ---------------------------------------------------------------------------
// fvp_back
// Pipelined CORDIC vectoring, quadrant mapping, gain correction and the
// output register. The whole pipeline holds while a result is stalled.
// ---------------------------------------------------------------------------
module fvp_back #(
	parameter int FORCE_BITS    = fvp_pkg::FORCE_BITS_DEF,
	parameter int CORDIC_STAGES = fvp_pkg::CORDIC_STAGES_DEF,
	parameter int ENTRY_W = 2 * FORCE_BITS + fvp_pkg::CLS_BITS + 2 + fvp_pkg::DUTY_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fvp_pkg::q_stat_t                 q_stat,
	input  logic [ENTRY_W-1:0]               pop_data,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [fvp_pkg::DEG_BITS-1:0]     angle_deg,
	output logic [FORCE_BITS-1:0]            magnitude,
	output logic                             dir_a,
	output logic                             dir_b,
	output logic [fvp_pkg::DUTY_BITS-1:0]    duty
);

	localparam int CW        = fvp_pkg::COMP_BITS;
	localparam int ZB        = fvp_pkg::Z_BITS;
	localparam int DB        = fvp_pkg::DUTY_BITS;
	localparam int FRAC_BITS = fvp_pkg::FRAC_TOP - FORCE_BITS;
	localparam int DEG_PW    = 32 + fvp_pkg::DEG_BITS;

	logic adv;

	// Unpacked queue head
	logic [FORCE_BITS-1:0] q_ax, q_ay;
	fvp_pkg::cls_t         q_cls;
	logic                  q_dira, q_dirb;
	logic [DB-1:0]         q_duty;

	// CORDIC stage registers
	logic                 v_s    [CORDIC_STAGES];
	logic signed [CW-1:0] cx_s   [CORDIC_STAGES];
	logic signed [CW-1:0] cy_s   [CORDIC_STAGES];
	logic signed [ZB-1:0] z_s    [CORDIC_STAGES];
	fvp_pkg::cls_t        cls_s  [CORDIC_STAGES];
	logic                 dira_s [CORDIC_STAGES];
	logic                 dirb_s [CORDIC_STAGES];
	logic [DB-1:0]        duty_s [CORDIC_STAGES];

	// Angle mapping and gain multiply stage
	logic                 zl_neg, zl_big;
	logic [31:0]          zc, angle;
	logic [CW-1:0]        xv, gprod_hi, gprod_lo;
	logic                 v_s1;
	logic [31:0]          angle_s1;
	logic [CW-1:0]        prod_hi_s1;
	logic [31:0]          prod_lo_s1;
	logic                 dira_s1, dirb_s1;
	logic [DB-1:0]        duty_s1;

	// Rounding stage
	logic [DEG_PW-1:0]    deg_sum;
	logic [CW-1:0]        p_sum, p_rnd, mag_w;

	logic                          out_valid_q;
	logic [fvp_pkg::DEG_BITS-1:0]  angle_deg_q;
	logic [FORCE_BITS-1:0]         magnitude_q;
	logic                          dir_a_q, dir_b_q;
	logic [DB-1:0]                 duty_q;

	// Advance everything unless a finished result is held
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !q_stat.empty;

	assign {q_ax, q_ay, q_cls, q_dira, q_dirb, q_duty} = pop_data;

	// One micro-rotation per stage
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		logic                 v_i;
		logic signed [CW-1:0] x_i, y_i, dx, dy;
		logic signed [ZB-1:0] z_i, at;
		fvp_pkg::cls_t        cls_i;
		logic                 dira_i, dirb_i;
		logic [DB-1:0]        duty_i;

		if (k == 0) begin : g_first
			assign v_i    = pop;
			assign x_i    = $signed(CW'(q_ax) << FRAC_BITS);
			assign y_i    = $signed(CW'(q_ay) << FRAC_BITS);
			assign z_i    = '0;
			assign cls_i  = q_cls;
			assign dira_i = q_dira;
			assign dirb_i = q_dirb;
			assign duty_i = q_duty;
		end else begin : g_next
			assign v_i    = v_s[k-1];
			assign x_i    = cx_s[k-1];
			assign y_i    = cy_s[k-1];
			assign z_i    = z_s[k-1];
			assign cls_i  = cls_s[k-1];
			assign dira_i = dira_s[k-1];
			assign dirb_i = dirb_s[k-1];
			assign duty_i = duty_s[k-1];
		end

		assign dx = y_i >>> k;
		assign dy = x_i >>> k;
		assign at = $signed(ZB'(fvp_pkg::ATAN_TURN[k]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (adv)
				v_s[k] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!y_i[CW-1]) begin
					cx_s[k] <= x_i + dx;
					cy_s[k] <= y_i - dy;
					z_s[k]  <= z_i + at;
				end else begin
					cx_s[k] <= x_i - dx;
					cy_s[k] <= y_i + dy;
					z_s[k]  <= z_i - at;
				end
				cls_s[k]  <= cls_i;
				dira_s[k] <= dira_i;
				dirb_s[k] <= dirb_i;
				duty_s[k] <= duty_i;
			end
		end
	end

	// Clamp to the first quadrant and mirror by class
	always_comb begin
		zl_neg = z_s[CORDIC_STAGES-1][ZB-1];
		zl_big = z_s[CORDIC_STAGES-1] > $signed(ZB'(fvp_pkg::QUARTER_TURN));
		if (zl_neg)
			zc = '0;
		else if (zl_big)
			zc = fvp_pkg::QUARTER_TURN;
		else
			zc = z_s[CORDIC_STAGES-1][31:0];
		case (cls_s[CORDIC_STAGES-1])
			fvp_pkg::CLS_POS_X: angle = '0;
			fvp_pkg::CLS_NEG_X: angle = fvp_pkg::HALF_TURN;
			fvp_pkg::CLS_POS_Y: angle = fvp_pkg::QUARTER_TURN;
			fvp_pkg::CLS_NEG_Y: angle = fvp_pkg::THREE_QUARTER_TURN;
			fvp_pkg::CLS_Q1:    angle = zc;
			fvp_pkg::CLS_Q2:    angle = fvp_pkg::HALF_TURN - zc;
			fvp_pkg::CLS_Q3:    angle = fvp_pkg::HALF_TURN + zc;
			default:            angle = '0 - zc;
		endcase
	end

	// Split the final x component and scale by the inverse gain
	always_comb begin
		xv       = cx_s[CORDIC_STAGES-1][CW-1] ? '0 : cx_s[CORDIC_STAGES-1];
		gprod_hi = CW'(xv[CW-1:32]) * CW'(fvp_pkg::INV_GAIN_Q32);
		gprod_lo = CW'(xv[31:0]) * CW'(fvp_pkg::INV_GAIN_Q32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= v_s[CORDIC_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s1   <= angle;
			prod_hi_s1 <= gprod_hi;
			prod_lo_s1 <= gprod_lo[CW-1:32];
			dira_s1    <= dira_s[CORDIC_STAGES-1];
			dirb_s1    <= dirb_s[CORDIC_STAGES-1];
			duty_s1    <= duty_s[CORDIC_STAGES-1];
		end
	end

	// Round angle to whole degrees and magnitude to whole units
	always_comb begin
		deg_sum = DEG_PW'(angle_s1) * DEG_PW'(fvp_pkg::DEG_TURN) +
			DEG_PW'(fvp_pkg::HALF_TURN);
		p_sum   = prod_hi_s1 + CW'(prod_lo_s1);
		p_rnd   = p_sum + (CW'(1) << (FRAC_BITS - 1));
		mag_w   = p_rnd >> FRAC_BITS;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_deg_q <= deg_sum[DEG_PW-1:32];
			magnitude_q <= mag_w[FORCE_BITS-1:0];
			dir_a_q     <= dira_s1;
			dir_b_q     <= dirb_s1;
			duty_q      <= duty_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign angle_deg = angle_deg_q;
	assign magnitude = magnitude_q;
	assign dir_a     = dir_a_q;
	assign dir_b     = dir_b_q;
	assign duty      = duty_q;

endmodule

[hw/rtl/force_vector_polar_motor_drive_unit.sv]
// ---------------------------------------------------------------------------
// force_vector_polar_motor_drive_unit
// Force direction and magnitude by CORDIC vectoring, plus H-bridge drive.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall carry force_x, force_y and speed_z.
//   Output channel: out_valid/out_stall carry angle_deg, magnitude, dir_a,
//   dir_b and duty, one result per request, in request order.
//   Configuration: wr_en/wr_idx/wr_data write duty_per_unit (index 0) and
//   pwm_period (index 1); write only while no request is in flight.
//   Path: a request passes the input register, the queue, the CORDIC stage
//   registers, the angle and gain register and the output register to out_valid.
//   Throughput: one request per cycle while no result is stalled, set by the
//   fully pipelined CORDIC with one micro-rotation per stage.
//   Reset: arst_n clears the pipeline, the queue and loads the register
//   defaults (1000 counts per unit, period 5000000).
//   Stall: a stalled result holds on the outputs and the back end freezes;
//   the front keeps taking requests until its four-entry queue, counting
//   the request in its input register, would be full, then raises in_stall.
// ---------------------------------------------------------------------------
module force_vector_polar_motor_drive_unit #(
	parameter int FORCE_BITS    = fvp_pkg::FORCE_BITS_DEF,
	parameter int CORDIC_STAGES = fvp_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [FORCE_BITS-1:0]          force_x,
	input  logic signed [FORCE_BITS-1:0]          force_y,
	input  logic signed [fvp_pkg::SPEED_BITS-1:0] speed_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [fvp_pkg::DEG_BITS-1:0]          angle_deg,
	output logic [FORCE_BITS-1:0]                 magnitude,
	output logic                                  dir_a,
	output logic                                  dir_b,
	output logic [fvp_pkg::DUTY_BITS-1:0]         duty,
	input  logic                                  wr_en,
	input  logic [fvp_pkg::WR_IDX_BITS-1:0]       wr_idx,
	input  logic [fvp_pkg::WR_DATA_BITS-1:0]      wr_data
);

	localparam int ENTRY_W = 2 * FORCE_BITS + fvp_pkg::CLS_BITS + 2 + fvp_pkg::DUTY_BITS;

	fvp_pkg::q_stat_t   q_stat;
	logic               push, pop;
	logic [ENTRY_W-1:0] push_data, pop_data;

	// Classify requests
	fvp_front #(
		.FORCE_BITS (FORCE_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.force_x   (force_x),
		.force_y   (force_y),
		.speed_z   (speed_z),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Decouple front and back
	fvp_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// Carry out CORDIC and rounding
	fvp_back #(
		.FORCE_BITS    (FORCE_BITS),
		.CORDIC_STAGES (CORDIC_STAGES),
		.ENTRY_W       (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.angle_deg (angle_deg),
		.magnitude (magnitude),
		.dir_a     (dir_a),
		.dir_b     (dir_b),
		.duty      (duty)
	);

endmodule

[hw/rtl/fvp_checker.sv]
// ---------------------------------------------------------------------------
// fvp_checker
// Port-level checks on the results of the motor drive unit.
// ---------------------------------------------------------------------------
`include "force_vector_polar_motor_drive_unit_defines.svh"

module fvp_checker #(
	parameter int FORCE_BITS = fvp_pkg::FORCE_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [fvp_pkg::DEG_BITS-1:0]       angle_deg,
	input logic [FORCE_BITS-1:0]              magnitude,
	input logic                               dir_a,
	input logic                               dir_b,
	input logic [fvp_pkg::DUTY_BITS-1:0]      duty
);

	// Bridge pins are never driven together
	`FVP_ASSERT_SAME(a_dir_excl, out_valid, !(dir_a && dir_b), "both bridge pins high")

	// Direction stays within one turn
	`FVP_ASSERT_SAME(a_deg_range, out_valid, angle_deg <= fvp_pkg::DEG_TURN, "angle above 360")

	// Zero speed gives zero duty
	`FVP_ASSERT_SAME(a_idle_duty, out_valid && !dir_a && !dir_b, duty == '0,
		"duty without direction")

	// A stalled request holds
	`FVP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(angle_deg) && $stable(magnitude) && $stable(duty),
		"stalled result changed")

endmodule

bind force_vector_polar_motor_drive_unit fvp_checker #(
	.FORCE_BITS (FORCE_BITS)
) u_fvp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.angle_deg (angle_deg),
	.magnitude (magnitude),
	.dir_a     (dir_a),
	.dir_b     (dir_b),
	.duty      (duty)
);

[tb/fvp_tb_pkg.sv]
// ---------------------------------------------------------------------------
// fvp_tb_pkg
// Expected-result calculator and result store for the motor drive testbench.
// ---------------------------------------------------------------------------
package fvp_tb_pkg;

	localparam int FB         = fvp_pkg::FORCE_BITS_DEF;
	localparam int STAGES     = fvp_pkg::CORDIC_STAGES_DEF;
	localparam int FRAC       = 60 - FB;
	localparam int SB         = fvp_pkg::SPEED_BITS;
	localparam int DB         = fvp_pkg::DUTY_BITS;
	localparam int AB         = fvp_pkg::DEG_BITS;

	localparam longint unsigned GAIN_INV   = 64'd2608131496;
	localparam longint unsigned TURN_Q     = 64'd1073741824;
	localparam longint unsigned TURN_H     = 64'd2147483648;
	localparam longint unsigned TURN_3Q    = 64'd3221225472;
	localparam longint unsigned TURN_FULL  = 64'd4294967296;

	// atan(2^-i) with a full turn of 2^32
	localparam longint ROT_STEP [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
		5, 3, 1, 1, 0
	};

	typedef struct {
		logic [AB-1:0] angle;
		logic [FB-1:0] mag;
		logic          pin_a;
		logic          pin_b;
		logic [DB-1:0] duty;
	} drive_result_t;

	class drive_scoreboard;
		longint unsigned dpu;
		longint unsigned period;
		drive_result_t   awaited [$];
		int              errors;

		function new();
			dpu    = 1000;
			period = 5000000;
			errors = 0;
		endfunction

		function void set_reg(logic [fvp_pkg::WR_IDX_BITS-1:0] idx,
		                      logic [fvp_pkg::WR_DATA_BITS-1:0] val);
			if (idx == fvp_pkg::REG_DUTY_PER_UNIT) begin
				dpu = val[15:0];
			end else if (idx == fvp_pkg::REG_PWM_PERIOD) begin
				period = val[23:0];
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Work out direction, length and bridge drive of one request
		function drive_result_t polar_drive(logic signed [FB-1:0] fx,
		                                    logic signed [FB-1:0] fy,
		                                    logic signed [SB-1:0] sp);
			longint          sx, sy, ss, cx, cy, z, dx, dy;
			longint unsigned ang, deg, xv, hi, lo, p, mag, dt;
			drive_result_t   r;
			sx = fx;
			sy = fy;
			ss = sp;
			cx = (sx < 0 ? -sx : sx) <<< FRAC;
			cy = (sy < 0 ? -sy : sy) <<< FRAC;
			z  = 0;
			// Rotate towards the x axis, one micro-rotation per stage
			for (int i = 0; i < STAGES && i < 32; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx = cx + dx;
					cy = cy - dy;
					z  = z + ROT_STEP[i];
				end else begin
					cx = cx - dx;
					cy = cy + dy;
					z  = z - ROT_STEP[i];
				end
			end
			if (z < 0)
				z = 0;
			if (z > longint'(TURN_Q))
				z = longint'(TURN_Q);

			// Mirror into the quadrant; axes are exact
			if (sy == 0)
				ang = (sx >= 0) ? 64'd0 : TURN_H;
			else if (sx == 0)
				ang = (sy > 0) ? TURN_Q : TURN_3Q;
			else if (sx > 0 && sy > 0)
				ang = longint'(z);
			else if (sx < 0 && sy > 0)
				ang = TURN_H - longint'(z);
			else if (sx < 0)
				ang = TURN_H + longint'(z);
			else
				ang = TURN_FULL - longint'(z);
			ang = ang & 64'hFFFF_FFFF;
			deg = (ang * 64'd360 + TURN_H) >> 32;

			// Scale by the inverse gain in two halves, then round
			if (sx == 0 && sy == 0) begin
				mag = 0;
			end else begin
				xv  = (cx < 0) ? 64'd0 : longint'(cx);
				hi  = xv >> 32;
				lo  = xv & 64'hFFFF_FFFF;
				p   = hi * GAIN_INV + ((lo * GAIN_INV) >> 32);
				mag = (p + (64'd1 << (FRAC - 1))) >> FRAC;
			end

			dt = longint'(ss < 0 ? -ss : ss) * dpu;
			if (dt > period)
				dt = period;

			r.angle = deg[AB-1:0];
			r.mag   = mag[FB-1:0];
			r.pin_a = (ss > 0);
			r.pin_b = (ss < 0);
			r.duty  = dt[DB-1:0];
			return r;
		endfunction

		function void note_request(logic signed [FB-1:0] fx, logic signed [FB-1:0] fy,
		                           logic signed [SB-1:0] sp);
			awaited.push_back(polar_drive(fx, fy, sp));
		endfunction

		task report_mismatch(string what, longint unsigned got, longint unsigned want);
			$display("ERROR %s: got %0d, expected %0d", what, got, want);
			errors++;
		endtask

		// Compare one delivered result against the oldest awaited one
		task check_result(logic [AB-1:0] angle, logic [FB-1:0] mag, logic pin_a,
		                  logic pin_b, logic [DB-1:0] duty);
			drive_result_t w;
			if (awaited.size() == 0) begin
				report_mismatch("result with no request outstanding", angle, 0);
			end else begin
				w = awaited.pop_front();
				if (angle !== w.angle)
					report_mismatch("angle_deg", angle, w.angle);
				if (mag !== w.mag)
					report_mismatch("magnitude", mag, w.mag);
				if (pin_a !== w.pin_a)
					report_mismatch("dir_a", pin_a, w.pin_a);
				if (pin_b !== w.pin_b)
					report_mismatch("dir_b", pin_b, w.pin_b);
				if (duty !== w.duty)
					report_mismatch("duty", duty, w.duty);
			end
		endtask
	endclass

endpackage

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the force vector polar motor drive unit: directed
// corner requests, then random requests over several register settings, with
// random gaps and stalls on both channels checked against a local predictor.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = fvp_tb_pkg::FB;
	localparam int SB = fvp_tb_pkg::SB;
	localparam int DB = fvp_tb_pkg::DB;
	localparam int AB = fvp_tb_pkg::AB;

	localparam int PIPE_LATENCY = fvp_pkg::CORDIC_STAGES_DEF + 4;
	localparam int HANG_LIMIT   = 4000;
	localparam int PHASE_ITEMS  = 85;

	logic                                clk      = 1'b0;
	logic                                arst_n   = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic signed [FB-1:0]                force_x  = '0;
	logic signed [FB-1:0]                force_y  = '0;
	logic signed [SB-1:0]                speed_z  = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [AB-1:0]                       angle_deg;
	logic [FB-1:0]                       magnitude;
	logic                                dir_a;
	logic                                dir_b;
	logic [DB-1:0]                       duty;
	logic                                wr_en   = 1'b0;
	logic [fvp_pkg::WR_IDX_BITS-1:0]     wr_idx  = '0;
	logic [fvp_pkg::WR_DATA_BITS-1:0]    wr_data = '0;

	logic                        calm = 1'b0;
	int                          hang_cycles = 0;
	fvp_tb_pkg::drive_scoreboard sb = new();

	force_vector_polar_motor_drive_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.force_x   (force_x),
		.force_y   (force_y),
		.speed_z   (speed_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.angle_deg (angle_deg),
		.magnitude (magnitude),
		.dir_a     (dir_a),
		.dir_b     (dir_b),
		.duty      (duty),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Present one request, with a random gap first, and hold it until taken
	task send_request(logic signed [FB-1:0] fx, logic signed [FB-1:0] fy,
	                  logic signed [SB-1:0] sp);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		force_x  <= fx;
		force_y  <= fy;
		speed_z  <= sp;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(fx, fy, sp);
	endtask

	// Drop valid and wait for every awaited result
	task drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Leave the write enable high; the caller drops it after the last write
	task write_reg(logic [fvp_pkg::WR_IDX_BITS-1:0] idx,
	               logic [fvp_pkg::WR_DATA_BITS-1:0] val);
		wr_en   <= 1'b1;
		wr_idx  <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task set_drive(logic [15:0] dpu, logic [23:0] period);
		drain_results();
		write_reg(fvp_pkg::REG_DUTY_PER_UNIT, {8'd0, dpu});
		write_reg(fvp_pkg::REG_PWM_PERIOD, period);
		wr_en <= 1'b0;
	endtask

	// Full-width values half the time, with small, zero and extreme ones mixed in
	function logic signed [FB-1:0] pick_force();
		int unsigned k;
		int          v;
		k = $urandom_range(9);
		if (k <= 4) begin
			return FB'($urandom);
		end else if (k <= 6) begin
			v = $urandom_range(63);
			return ($urandom_range(1) != 0) ? FB'(-v) : FB'(v);
		end else if (k == 7) begin
			return '0;
		end else begin
			case ($urandom_range(3))
				0: return FB'(131071);
				1: return FB'(-131072);
				2: return FB'(1);
				default: return FB'(-1);
			endcase
		end
	endfunction

	function logic signed [SB-1:0] pick_speed();
		int unsigned k;
		k = $urandom_range(9);
		if (k <= 6)
			return SB'(int'($urandom_range(10000)) - 5000);
		else if (k <= 8)
			return SB'($urandom);
		else
			return '0;
	endfunction

	task random_phase(int n);
		repeat (n)
			send_request(pick_force(), pick_force(), pick_speed());
	endtask

	// Sample results and choose the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(angle_deg, magnitude, dir_a, dir_b, duty);
		out_stall <= !calm && ($urandom_range(99) < 37);
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			hang_cycles <= 0;
		else
			hang_cycles <= hang_cycles + 1;
		if (hang_cycles >= HANG_LIMIT) begin
			$display("force_vector_polar_motor_drive_unit: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner requests at the reset register values
		send_request('0, '0, '0);
		send_request(FB'(131071), '0, SB'(5000));
		send_request(FB'(-131072), '0, SB'(-5000));
		send_request('0, FB'(131071), SB'(1));
		send_request('0, FB'(-131072), SB'(-1));
		send_request(FB'(131071), FB'(131071), SB'(8191));
		send_request(FB'(-131072), FB'(-131072), SB'(-8192));
		send_request(FB'(131071), FB'(-131072), SB'(4999));
		send_request(FB'(-131072), FB'(131071), SB'(-4999));
		send_request(FB'(1), FB'(1), '0);
		send_request(FB'(-1), FB'(-1), SB'(2));
		send_request(FB'(1), FB'(-1), SB'(-2));
		send_request(FB'(-1), FB'(1), SB'(5001));
		send_request(FB'(1), '0, SB'(-5001));
		send_request(FB'(-1), '0, SB'(100));
		send_request('0, FB'(1), SB'(-100));
		send_request('0, FB'(-1), SB'(8191));
		// Just below a full turn rounds up to 360
		send_request(FB'(131071), FB'(-1), SB'(3000));
		send_request(FB'(131071), FB'(1), SB'(-3000));
		send_request(FB'(-131072), FB'(-1), SB'(-8192));
		send_request(FB'(-131072), FB'(1), '0);

		// Random requests over a spread of register settings
		set_drive(16'd0, 24'hFF_FFFF);
		random_phase(PHASE_ITEMS);
		set_drive(16'hFFFF, 24'd1);
		random_phase(PHASE_ITEMS);
		set_drive(16'($urandom), 24'($urandom_range(24'hFF_FFFF, 1)));
		calm = 1'b1;
		random_phase(PHASE_ITEMS);
		calm = 1'b0;
		// Zero period clamps every duty to nothing
		set_drive(16'd1000, 24'd0);
		random_phase(PHASE_ITEMS);
		set_drive(16'hFFFF, 24'hFF_FFFF);
		random_phase(PHASE_ITEMS);
		set_drive(16'($urandom_range(2000, 1)), 24'($urandom_range(5000000, 1)));
		random_phase(PHASE_ITEMS);

		drain_results();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (sb.errors == 0) begin
			$display("force_vector_polar_motor_drive_unit: match");
		end else begin
			$display("force_vector_polar_motor_drive_unit: mismatch");
		end
		$finish;
	end

endmodule
